FILE: hdl/pbms_pkg.sv
package pbms_pkg;

  localparam int LINE_BITS  = 32;
  localparam int COUNT_BITS = 16;

  localparam int NUM_NAMES = 15;
  localparam int NUM_DIRS  = 4;
  localparam int NAME_MAX  = 18;
  localparam int DIR_MAX   = 6;
  localparam int LEN_BITS  = 5;

  localparam logic [LEN_BITS-1:0] LEN_SAT = '1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_USCR  = 8'h5F;

  // Names are right-justified: the last character sits in the low byte.
  localparam logic [NAME_MAX*8-1:0] NAME_STR [NUM_NAMES] = '{
    (NAME_MAX*8)'("_WIN32"), (NAME_MAX*8)'("_WIN64"),
    (NAME_MAX*8)'({"_MSC", "_VER"}),
    (NAME_MAX*8)'("__MINGW32__"), (NAME_MAX*8)'("__MINGW64__"),
    (NAME_MAX*8)'("__CYGWIN__"), (NAME_MAX*8)'("__APPLE__"),
    (NAME_MAX*8)'("__linux__"), (NAME_MAX*8)'("__FreeBSD__"),
    (NAME_MAX*8)'({"__FreeBSD", "_kernel__"}), (NAME_MAX*8)'("__NetBSD__"),
    (NAME_MAX*8)'("__OpenBSD__"), (NAME_MAX*8)'("__DragonFly__"),
    (NAME_MAX*8)'("__ANDROID__"), (NAME_MAX*8)'("__dietlibc__")
  };

  localparam logic [LEN_BITS-1:0] NAME_LEN [NUM_NAMES] = '{
    5'd6, 5'd6, 5'd8, 5'd11, 5'd11, 5'd10, 5'd9, 5'd9, 5'd11, 5'd18,
    5'd10, 5'd11, 5'd13, 5'd11, 5'd12
  };

  localparam logic [DIR_MAX*8-1:0] DIR_STR [NUM_DIRS] = '{
    (DIR_MAX*8)'("if"), (DIR_MAX*8)'("ifdef"),
    (DIR_MAX*8)'("ifndef"), (DIR_MAX*8)'("elif")
  };

  localparam logic [LEN_BITS-1:0] DIR_LEN [NUM_DIRS] = '{5'd2, 5'd5, 5'd6, 5'd4};

  function automatic logic is_id_start(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCR;
  endfunction

  function automatic logic is_id_char(logic [7:0] c);
    return is_id_start(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

FILE: hdl/pbms_text_if.sv
interface pbms_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

FILE: hdl/pbms_line_if.sv
interface pbms_line_if
  import pbms_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [LINE_BITS-1:0]  line_index;
  logic                  line_flagged;
  logic [COUNT_BITS-1:0] flag_total;
  logic                  text_done;

  modport source (output valid, output line_index, output line_flagged,
                  output flag_total, output text_done, input ready);
  modport sink   (input valid, input line_index, input line_flagged,
                  input flag_total, input text_done, output ready);
endinterface

FILE: hdl/preproc_banned_macro_scanner.sv
// Conditional-directive scanner for host-specific macro names.
//
// text (sink): one source character per transaction, text_byte plus
//   final_byte, which marks the last character of a text. Byte 0x0A ends a line.
// report (source): one transaction per line end: line_index (from one per
//   text), line_flagged (line is #if/#ifdef/#ifndef/#elif whose expression
//   names one of fifteen host macros), flag_total (saturating running count,
//   kept across texts) and text_done (the line also ended the text).
//
// A line result is registered into the output buffer when the transaction that
// ends the line is accepted. Throughput: one character per cycle while text.ready
// is high; the scan state is a single register updated by one pass of logic per
// character. A two-entry output buffer (output register plus skid register) lets
// characters keep flowing while one result waits; text.ready drops only when both
// entries are full, i.e. the receiver has stalled across two results.
//
// Reset (rst, synchronous): scanner at line start, line number one, flag count
// zero, output buffer empty.
module preproc_banned_macro_scanner
  import pbms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pbms_text_if.sink    text,
  pbms_line_if.source  report
);

  typedef enum logic [12:0] {
    PH_LEAD     = 13'b0000000000001,
    PH_HASH     = 13'b0000000000010,
    PH_DIR      = 13'b0000000000100,
    PH_IDLE     = 13'b0000000001000,
    PH_EXPR     = 13'b0000000010000,
    PH_SLASH    = 13'b0000000100000,
    PH_IDENT    = 13'b0000001000000,
    PH_DQ       = 13'b0000010000000,
    PH_DQ_ESC   = 13'b0000100000000,
    PH_SQ       = 13'b0001000000000,
    PH_SQ_ESC   = 13'b0010000000000,
    PH_CMT      = 13'b0100000000000,
    PH_CMT_STAR = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [NUM_DIRS-1:0]   dc;
    logic [LEN_BITS-1:0]   tl;
    logic [NUM_NAMES-1:0]  kc;
    logic                  hit;
  } scan_t;

  typedef struct packed {
    logic [LINE_BITS-1:0]  line_index;
    logic                  line_flagged;
    logic [COUNT_BITS-1:0] flag_total;
    logic                  text_done;
  } rec_t;

  // ---------------------------------------------------------------------------
  // Per-character scan functions
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] name_byte(int i, logic [LEN_BITS-1:0] k);
    logic [7:0] sh;
    sh = {3'b000, NAME_LEN[i] - 5'd1 - k};
    return 8'(NAME_STR[i] >> {sh[4:0], 3'b000});
  endfunction

  function automatic logic [7:0] dir_byte(int i, logic [LEN_BITS-1:0] k);
    logic [7:0] sh;
    sh = {3'b000, DIR_LEN[i] - 5'd1 - k};
    return 8'(DIR_STR[i] >> {sh[4:0], 3'b000});
  endfunction

  function automatic logic [LEN_BITS-1:0] bump(logic [LEN_BITS-1:0] tl);
    return (tl != LEN_SAT) ? tl + 5'd1 : tl;
  endfunction

  function automatic logic ident_complete(scan_t s);
    logic r;
    r = 1'b0;
    for (int i = 0; i < NUM_NAMES; i++) begin
      if (s.kc[i] && NAME_LEN[i] == s.tl) r = 1'b1;
    end
    return r;
  endfunction

  function automatic scan_t ident_char(scan_t s, logic [7:0] c);
    scan_t r;
    r = s;
    for (int i = 0; i < NUM_NAMES; i++) begin
      r.kc[i] = s.kc[i] && (s.tl < NAME_LEN[i]) && (name_byte(i, s.tl) == c);
    end
    r.tl = bump(s.tl);
    return r;
  endfunction

  function automatic scan_t expr_char(scan_t s, logic [7:0] c);
    scan_t r;
    r = s;
    if (c == CH_DQ) begin
      r.phase = PH_DQ;
    end else if (c == CH_SQ) begin
      r.phase = PH_SQ;
    end else if (c == CH_SLASH) begin
      r.phase = PH_SLASH;
    end else if (is_id_start(c)) begin
      r.phase = PH_IDENT;
      r.kc    = '1;
      r.tl    = '0;
      r     = ident_char(r, c);
    end else begin
      r.phase = PH_EXPR;
    end
    return r;
  endfunction

  function automatic scan_t dir_char(scan_t s, logic [7:0] c);
    scan_t               r;
    logic [NUM_DIRS-1:0] nxt;
    logic                done;
    r    = s;
    nxt  = '0;
    done = 1'b0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (s.dc[i]) begin
        if (s.tl < DIR_LEN[i]) begin
          nxt[i] = (dir_byte(i, s.tl) == c);
        end else if (s.tl == DIR_LEN[i] && !is_id_char(c)) begin
          done = 1'b1;
        end
      end
    end
    r.dc = nxt;
    if (done) begin
      r.dc = '0;
      r    = expr_char(r, c);
    end else if (nxt == '0) begin
      r.phase = PH_IDLE;
    end else begin
      r.tl = bump(s.tl);
    end
    return r;
  endfunction

  function automatic scan_t scan_char(scan_t s, logic [7:0] c);
    scan_t r;
    r = s;
    unique case (s.phase)
      PH_LEAD: begin
        if (c == CH_HASH) r.phase = PH_HASH;
        else if (c != CH_SPACE && c != CH_TAB) r.phase = PH_IDLE;
      end
      PH_HASH: begin
        if (c != CH_SPACE && c != CH_TAB) begin
          r.phase = PH_DIR;
          r.dc    = '1;
          r.tl    = '0;
          r     = dir_char(r, c);
        end
      end
      PH_DIR:  r = dir_char(s, c);
      PH_EXPR: r = expr_char(s, c);
      PH_SLASH: begin
        if (c == CH_SLASH) r.phase = PH_IDLE;
        else if (c == CH_STAR) r.phase = PH_CMT;
        else r = expr_char(s, c);
      end
      PH_IDENT: begin
        if (is_id_char(c)) begin
          r = ident_char(s, c);
        end else begin
          if (ident_complete(s)) r.hit = 1'b1;
          r.kc = '0;
          r    = expr_char(r, c);
        end
      end
      PH_DQ: begin
        if (c == CH_BSL) r.phase = PH_DQ_ESC;
        else if (c == CH_DQ) r.phase = PH_EXPR;
      end
      PH_DQ_ESC: r.phase = PH_DQ;
      PH_SQ: begin
        if (c == CH_BSL) r.phase = PH_SQ_ESC;
        else if (c == CH_SQ) r.phase = PH_EXPR;
      end
      PH_SQ_ESC: r.phase = PH_SQ;
      PH_CMT: begin
        if (c == CH_STAR) r.phase = PH_CMT_STAR;
      end
      PH_CMT_STAR: begin
        if (c == CH_SLASH) r.phase = PH_EXPR;
        else if (c != CH_STAR) r.phase = PH_CMT;
      end
      default: r = s;  // idle: skip the rest of the line
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  scan_t                 scan, scan_next;
  logic [LINE_BITS-1:0]  line_counter, line_counter_next;
  logic [COUNT_BITS-1:0] flag_counter, flag_counter_next;

  // Output buffer: head register drives the port, skid absorbs one more.
  rec_t out_rec, skid_rec, new_rec;
  logic out_valid, skid_valid;
  logic emit;

  logic accept;
  logic drain;
  logic is_lf;
  logic line_hit;
  scan_t scanned;

  assign accept = text.valid && text.ready;
  assign drain  = !out_valid || report.ready;
  assign is_lf  = (text.text_byte == CH_LF);

  // Hold input while both buffer entries are taken.
  assign text.ready = !skid_valid;

  always_comb begin
    scanned           = is_lf ? scan : scan_char(scan, text.text_byte);
    emit              = accept && (is_lf || text.final_byte);
    line_hit          = scanned.hit || (scanned.phase == PH_IDENT && ident_complete(scanned));
    scan_next         = scan;
    line_counter_next = line_counter;
    flag_counter_next = flag_counter;
    if (accept) begin
      scan_next = scanned;
    end
    if (emit) begin
      if (line_hit && flag_counter != '1) flag_counter_next = flag_counter + 1'b1;
      if (text.final_byte) line_counter_next = LINE_BITS'(1);
      else if (line_counter != '1) line_counter_next = line_counter + 1'b1;
      // Line end: drop all per-line context.
      scan_next.phase = PH_LEAD;
      scan_next.dc    = '0;
      scan_next.tl    = '0;
      scan_next.kc    = '0;
      scan_next.hit   = 1'b0;
    end
    new_rec.line_index   = line_counter;
    new_rec.line_flagged = line_hit;
    new_rec.flag_total   = flag_counter_next;
    new_rec.text_done    = text.final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.phase   <= PH_LEAD;
      scan.dc      <= '0;
      scan.tl      <= '0;
      scan.kc      <= '0;
      scan.hit     <= 1'b0;
      line_counter <= LINE_BITS'(1);
      flag_counter <= '0;
    end else begin
      scan         <= scan_next;
      line_counter <= line_counter_next;
      flag_counter <= flag_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      // Advance: skid first, else a fresh result, else go empty.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) out_rec <= skid_rec;
      else if (emit) out_rec <= new_rec;
    end else if (emit) begin
      skid_rec <= new_rec;
    end
  end

  assign report.valid        = out_valid;
  assign report.line_index   = out_rec.line_index;
  assign report.line_flagged = out_rec.line_flagged;
  assign report.flag_total   = out_rec.flag_total;
  assign report.text_done    = out_rec.text_done;

`ifndef ASSERT_OFF
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a head entry");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !report.ready))
    else $error("skid filled while head was free");

  a_line_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && (is_lf || text.final_byte)) |=> (scan.phase == PH_LEAD && scan.kc == '0))
    else $error("line context survived a line end");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> flag_counter >= $past(flag_counter))
    else $error("flag count went down");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_counter != '0)
    else $error("line number reached zero");
`endif

endmodule
